### sv/ptm_pkg.sv
// ----------------------------------------------------------------------------
// ptm_pkg
// Codes shared by the process table manager and its port checker.
// ----------------------------------------------------------------------------
package ptm_pkg;

    // request modes
    localparam logic [1:0] MODE_SPAWN     = 2'd0;
    localparam logic [1:0] MODE_SPAWN_TOP = 2'd1;
    localparam logic [1:0] MODE_FINISH    = 2'd2;
    localparam logic [1:0] MODE_JOIN      = 2'd3;

    // result status
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_ILLEGAL = 2'd2;
    localparam logic [1:0] STATUS_PENDING = 2'd3;

    // slot states
    localparam logic [1:0] ST_FREE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_ZOMBIE = 2'd2;

    // slot number that means no slot
    localparam logic [5:0] SLOT_NONE = 6'h3f;

endpackage

### sv/process_table_manager.sv
// The process table lives in one single-port-read, single-port-write memory
// with one row per slot (state, parent, first child, next sibling, exit code)
// and a valid bit per row that makes an unwritten row read as a free slot.
// One request word is handled at a time; every table read is registered, so
// each access has its own state. A spawn scans the table for a free slot and
// walks the sibling chain of the caller's children; a finish visits each child
// and walks the parent's child list for each zombie child it frees. The table
// memory port is what sets the pace. A result word waits in an output register
// while the next request is taken.
// ----------------------------------------------------------------------------
// process_table_manager
// Spawn, finish and join on a fixed table of process slots.
// ----------------------------------------------------------------------------
module process_table_manager #(
    parameter int MAX_PROCS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic signed [5:0]  s_caller_slot,
    input  logic [4:0]         s_target_slot,
    input  logic signed [31:0] s_exit_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [5:0]  m_slot_out,
    output logic signed [31:0] m_joined_value
);
    import ptm_pkg::*;

    localparam int SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);

    typedef struct packed {
        logic          none;
        logic [SW-1:0] idx;
    } link_t;

    typedef struct packed {
        logic [1:0]  state;
        link_t       parent;
        link_t       fchild;
        link_t       sib;
        logic [31:0] exitv;
    } row_t;

    localparam link_t LINK_NONE = '{none: 1'b1, idx: '0};
    localparam row_t  RESET_ROW = '{state: ST_FREE, parent: LINK_NONE,
                                    fchild: LINK_NONE, sib: LINK_NONE,
                                    exitv: 32'd0};

    typedef enum logic [16:0] {
        S_IDLE     = 17'h00001,
        S_START    = 17'h00002,
        S_CALLER   = 17'h00004,
        S_SCAN     = 17'h00008,
        S_SCAN_CHK = 17'h00010,
        S_ALINK    = 17'h00020,
        S_AWALK    = 17'h00040,
        S_FLOOP    = 17'h00080,
        S_FCHILD   = 17'h00100,
        S_FEND     = 17'h00200,
        S_UNLINK   = 17'h00400,
        S_UPAR     = 17'h00800,
        S_UCTL     = 17'h01000,
        S_UWALK    = 17'h02000,
        S_FREE     = 17'h04000,
        S_JTGT     = 17'h08000,
        S_DONE     = 17'h10000
    } state_t;

    // table memory
    row_t                 slot_mem [MAX_PROCS];
    logic [MAX_PROCS-1:0] valid_reg;
    row_t                 rd_row_reg;
    logic                 rd_valid_reg;
    logic                 rd_en;
    logic [SW-1:0]        rd_addr;
    logic                 wr_en;
    logic [SW-1:0]        wr_addr;
    row_t                 wr_row;
    row_t                 row_q;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            rd_row_reg <= slot_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign row_q = rd_valid_reg ? rd_row_reg : RESET_ROW;

    // control and request registers
    state_t        state_reg, state_next;
    logic [1:0]    mode_reg, mode_next;
    logic [5:0]    caller_reg, caller_next;
    logic [4:0]    target_reg, target_next;
    logic [31:0]   exitv_reg, exitv_next;
    row_t          crow_reg, crow_next;
    logic [SW-1:0] rotor_reg, rotor_next;
    logic [SW-1:0] pos_reg, pos_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] ucnt_reg, ucnt_next;
    logic [SW-1:0] found_reg, found_next;
    link_t         c_reg, c_next;
    link_t         w_reg, w_next;
    logic [SW-1:0] s_reg, s_next;
    link_t         sib_s_reg, sib_s_next;
    link_t         p_reg, p_next;
    logic          ret_join_reg, ret_join_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [5:0]    res_slot_reg, res_slot_next;
    logic [31:0]   res_joined_reg, res_joined_next;
    logic          m_valid_reg, m_valid_next;
    logic [1:0]    m_status_reg, m_status_next;
    logic [5:0]    m_slot_reg, m_slot_next;
    logic [31:0]   m_joined_reg, m_joined_next;

    logic          caller_ok;
    logic [SW-1:0] caller_idx;
    logic          target_ok;
    logic [SW-1:0] target_idx;
    row_t          tmp_row;

    assign caller_ok  = !caller_reg[5] && (32'(caller_reg[4:0]) < MAX_PROCS);
    assign caller_idx = SW'(caller_reg[4:0]);
    assign target_ok  = 32'(target_reg) < MAX_PROCS;
    assign target_idx = SW'(target_reg);

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_slot_out     = m_slot_reg;
    assign m_joined_value = m_joined_reg;

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        caller_next     = caller_reg;
        target_next     = target_reg;
        exitv_next      = exitv_reg;
        crow_next       = crow_reg;
        rotor_next      = rotor_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        ucnt_next       = ucnt_reg;
        found_next      = found_reg;
        c_next          = c_reg;
        w_next          = w_reg;
        s_next          = s_reg;
        sib_s_next      = sib_s_reg;
        p_next          = p_reg;
        ret_join_next   = ret_join_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_joined_next = res_joined_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        m_joined_next   = m_joined_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_row          = row_q;
        tmp_row         = row_q;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    mode_next   = s_mode;
                    caller_next = s_caller_slot;
                    target_next = s_target_slot;
                    exitv_next  = s_exit_value;
                    state_next  = S_START;
                end
            end
            S_START: begin
                res_status_next = STATUS_ILLEGAL;
                res_slot_next   = SLOT_NONE;
                res_joined_next = 32'd0;
                cnt_next        = '0;
                pos_next        = rotor_reg;
                case (mode_reg)
                    MODE_SPAWN_TOP: begin
                        state_next = S_SCAN;
                    end
                    MODE_JOIN: begin
                        if (caller_ok && target_ok) begin
                            rd_en      = 1'b1;
                            rd_addr    = target_idx;
                            state_next = S_JTGT;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    default: begin
                        if (caller_ok) begin
                            rd_en      = 1'b1;
                            rd_addr    = caller_idx;
                            state_next = S_CALLER;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                endcase
            end
            S_CALLER: begin
                crow_next = row_q;
                if (row_q.state != ST_RUN) begin
                    state_next = S_DONE;
                end else if (mode_reg == MODE_FINISH) begin
                    c_next     = row_q.fchild;
                    state_next = S_FLOOP;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                rd_en      = 1'b1;
                rd_addr    = pos_reg;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (row_q.state == ST_FREE) begin
                    found_next    = pos_reg;
                    rotor_next    = (32'(pos_reg) == MAX_PROCS - 1) ? '0 : pos_reg + 1'b1;
                    tmp_row       = RESET_ROW;
                    tmp_row.state = ST_RUN;
                    if (mode_reg == MODE_SPAWN) begin
                        tmp_row.parent = '{none: 1'b0, idx: caller_idx};
                    end
                    wr_en         = 1'b1;
                    wr_addr       = pos_reg;
                    wr_row        = tmp_row;
                    state_next    = S_ALINK;
                end else if (32'(cnt_reg) + 1 == MAX_PROCS) begin
                    res_status_next = STATUS_FULL;
                    state_next      = S_DONE;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    pos_next   = (32'(pos_reg) == MAX_PROCS - 1) ? '0 : pos_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_ALINK: begin
                res_status_next = STATUS_OK;
                res_slot_next   = 6'(found_reg);
                if (mode_reg != MODE_SPAWN) begin
                    state_next = S_DONE;
                end else if (crow_reg.fchild.none) begin
                    tmp_row        = crow_reg;
                    tmp_row.fchild = '{none: 1'b0, idx: found_reg};
                    wr_en          = 1'b1;
                    wr_addr        = caller_idx;
                    wr_row         = tmp_row;
                    state_next     = S_DONE;
                end else begin
                    c_next     = crow_reg.fchild;
                    cnt_next   = '0;
                    rd_en      = 1'b1;
                    rd_addr    = crow_reg.fchild.idx;
                    state_next = S_AWALK;
                end
            end
            S_AWALK: begin
                // follow the chain to its last sibling
                if ((32'(cnt_reg) < MAX_PROCS) && !row_q.sib.none) begin
                    c_next   = row_q.sib;
                    cnt_next = cnt_reg + 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = row_q.sib.idx;
                end else begin
                    tmp_row     = row_q;
                    tmp_row.sib = '{none: 1'b0, idx: found_reg};
                    wr_en       = 1'b1;
                    wr_addr     = c_reg.idx;
                    wr_row      = tmp_row;
                    state_next  = S_DONE;
                end
            end
            S_FLOOP: begin
                rd_en = 1'b1;
                if ((32'(cnt_reg) < MAX_PROCS) && !c_reg.none) begin
                    rd_addr    = c_reg.idx;
                    state_next = S_FCHILD;
                end else begin
                    rd_addr    = caller_idx;
                    state_next = S_FEND;
                end
            end
            S_FCHILD: begin
                cnt_next = cnt_reg + 1'b1;
                c_next   = row_q.sib;
                if (row_q.state == ST_ZOMBIE) begin
                    s_next        = c_reg.idx;
                    sib_s_next    = row_q.sib;
                    p_next        = row_q.parent;
                    ret_join_next = 1'b0;
                    state_next    = S_UNLINK;
                end else begin
                    // orphan a live child
                    tmp_row        = row_q;
                    tmp_row.parent = LINK_NONE;
                    tmp_row.sib    = LINK_NONE;
                    wr_en          = 1'b1;
                    wr_addr        = c_reg.idx;
                    wr_row         = tmp_row;
                    state_next     = S_FLOOP;
                end
            end
            S_FEND: begin
                res_status_next = STATUS_OK;
                wr_en           = 1'b1;
                wr_addr         = caller_idx;
                if (!row_q.parent.none) begin
                    tmp_row        = row_q;
                    tmp_row.fchild = LINK_NONE;
                    tmp_row.exitv  = exitv_reg;
                    tmp_row.state  = ST_ZOMBIE;
                    wr_row         = tmp_row;
                end else begin
                    wr_row = RESET_ROW;
                end
                state_next = S_DONE;
            end
            S_UNLINK: begin
                if (!p_reg.none) begin
                    rd_en      = 1'b1;
                    rd_addr    = p_reg.idx;
                    state_next = S_UPAR;
                end else begin
                    state_next = S_FREE;
                end
            end
            S_UPAR: begin
                if (!row_q.fchild.none && (row_q.fchild.idx == s_reg)) begin
                    tmp_row        = row_q;
                    tmp_row.fchild = sib_s_reg;
                    wr_en          = 1'b1;
                    wr_addr        = p_reg.idx;
                    wr_row         = tmp_row;
                    state_next     = S_FREE;
                end else begin
                    w_next     = row_q.fchild;
                    ucnt_next  = '0;
                    state_next = S_UCTL;
                end
            end
            S_UCTL: begin
                if ((32'(ucnt_reg) < MAX_PROCS) && !w_reg.none) begin
                    rd_en      = 1'b1;
                    rd_addr    = w_reg.idx;
                    state_next = S_UWALK;
                end else begin
                    state_next = S_FREE;
                end
            end
            S_UWALK: begin
                if (!row_q.sib.none && (row_q.sib.idx == s_reg)) begin
                    tmp_row     = row_q;
                    tmp_row.sib = sib_s_reg;
                    wr_en       = 1'b1;
                    wr_addr     = w_reg.idx;
                    wr_row      = tmp_row;
                    state_next  = S_FREE;
                end else begin
                    w_next     = row_q.sib;
                    ucnt_next  = ucnt_reg + 1'b1;
                    state_next = S_UCTL;
                end
            end
            S_FREE: begin
                wr_en   = 1'b1;
                wr_addr = s_reg;
                wr_row  = RESET_ROW;
                if (ret_join_reg) begin
                    res_status_next = STATUS_OK;
                    state_next      = S_DONE;
                end else begin
                    state_next = S_FLOOP;
                end
            end
            S_JTGT: begin
                if ((row_q.state != ST_FREE) && !row_q.parent.none &&
                    (row_q.parent.idx == caller_idx)) begin
                    if (row_q.state == ST_ZOMBIE) begin
                        res_joined_next = row_q.exitv;
                        s_next          = target_idx;
                        sib_s_next      = row_q.sib;
                        p_next          = row_q.parent;
                        ret_join_next   = 1'b1;
                        state_next      = S_UNLINK;
                    end else begin
                        res_status_next = STATUS_PENDING;
                        state_next      = S_DONE;
                    end
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_slot_next   = res_slot_reg;
                    m_joined_next = res_joined_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rotor_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rotor_reg   <= rotor_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        caller_reg     <= caller_next;
        target_reg     <= target_next;
        exitv_reg      <= exitv_next;
        crow_reg       <= crow_next;
        pos_reg        <= pos_next;
        cnt_reg        <= cnt_next;
        ucnt_reg       <= ucnt_next;
        found_reg      <= found_next;
        c_reg          <= c_next;
        w_reg          <= w_next;
        s_reg          <= s_next;
        sib_s_reg      <= sib_s_next;
        p_reg          <= p_next;
        ret_join_reg   <= ret_join_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_joined_reg <= res_joined_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
        m_joined_reg   <= m_joined_next;
    end

endmodule

### sv/ptm_checker.sv
// ----------------------------------------------------------------------------
// ptm_checker
// Port-level checks of the process table manager, bound to its top level.
// ----------------------------------------------------------------------------
module ptm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [5:0]  m_slot_out,
    input logic [31:0] m_joined_value
);
    import ptm_pkg::*;

    // only a good spawn hands out a slot
    a_slot_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STATUS_OK) |-> m_slot_out == SLOT_NONE)
        else $error("slot given with failing status");

    // a value comes back only from a good join, which allocates nothing
    a_joined_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_status != STATUS_OK) || (m_slot_out != SLOT_NONE))
        |-> m_joined_value == 32'd0)
        else $error("joined value on a word that is not a join");

    // one request at a time: busy right after a word is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice in a row");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot_out))
        else $error("result word changed while stalled");

endmodule

bind process_table_manager ptm_checker u_ptm_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_slot_out     (m_slot_out),
    .m_joined_value (m_joined_value)
);
